### hdl/particle_pool_euler_step_assert.svh
// ----------------------------------------------------------------------------
// particle_pool_euler_step_assert
// Assertion macros used by the particle pool RTL.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_EULER_STEP_ASSERT_SVH
`define PARTICLE_POOL_EULER_STEP_ASSERT_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define PPES_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define PPES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/ppes_pkg.sv
// ----------------------------------------------------------------------------
// ppes_pkg
// Types and constants for the particle pool Euler step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppes_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int ADDR_W        = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

  localparam logic [15:0] TIME_STEP_RESET = 16'd1092;
  localparam logic [9:0]  GRAVITY         = 10'd980;
  localparam logic signed [31:0] SPAWN_SPEED = 32'sd7864320; // 120.0 Q16.16
  localparam logic signed [31:0] LIFE_ONE    = 32'sd65536;   // 1.0 Q16.16

  localparam logic ACT_SPAWN = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  typedef enum logic {ALU_ADD, ALU_MUL} alu_op_t;

  typedef struct packed {
    logic    en;
    alu_op_t op;
  } alu_ctrl_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] spawn_x;
    logic signed [31:0] spawn_y;
    logic signed [31:0] spawn_z;
  } in_beat_t;

  typedef struct packed {
    logic [12:0] alive_count;
    logic        spawn_dropped;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] vz;
    logic signed [31:0] life;
  } particle_t;

endpackage

### hdl/ppes_alu.sv
// ----------------------------------------------------------------------------
// ppes_alu
// Shared Q16.16 unit: saturating add, or multiply by the step with floor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppes_alu (
  input  logic               clk,
  input  ppes_pkg::alu_ctrl_t ctrl,
  input  logic signed [31:0] a,
  input  logic signed [32:0] b,
  input  logic [15:0]        dt,
  output logic signed [31:0] res
);
  import ppes_pkg::*;

  logic signed [33:0] sum;
  logic signed [48:0] prod;
  logic signed [31:0] sat_sum;

  assign sum  = {{2{a[31]}}, a} + {b[32], b};
  assign prod = a * $signed({1'b0, dt});

  always_comb begin
    if (sum > 34'sh07FFFFFFF) begin
      sat_sum = 32'sh7FFFFFFF;
    end else if (sum < -34'sh080000000) begin
      sat_sum = 32'sh80000000;
    end else begin
      sat_sum = sum[31:0];
    end
  end

  // arithmetic shift of the product is floor; result always fits 32 bits
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.op)
        ALU_ADD: res <= sat_sum;
        ALU_MUL: res <= prod[47:16];
        default: res <= sat_sum;
      endcase
    end
  end

endmodule

### hdl/particle_pool_euler_step.sv
// ----------------------------------------------------------------------------
// particle_pool_euler_step
// Fixed pool of particles with spawn and explicit Euler step, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one beat: action (0 spawn, 1 step) and the spawn
//   position. out_valid/out_ready return one beat per input: the alive count
//   and a flag set when a spawn hit a full pool.
//   cfg_we/cfg_data write time_step (Q0.16); idle only is for the user to keep, the block does not enforce it.
// Sequencing:
//   A spawn goes from accept to S_DONE, which loads the output register and
//   returns to idle once the output register is free.
//   A step walks every live particle through the single shared ALU:
//   read, speed update, multiply, z update, life update, write back; then
//   S_DONE loads the result. The block takes a new beat only while idle.
// Reset:
//   rst clears the alive count and control; time_step returns to 1092.
//   in_ready is low while rst is high.
//   Particle memory is not cleared: only entries below the count are read.
// Stall:
//   A finished result sits in the output register; the next beat can be
//   accepted meanwhile, but its result waits until out_ready takes the first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_pool_euler_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppes_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ppes_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);
  import ppes_pkg::*;

  `include "particle_pool_euler_step_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_VZ, S_MUL, S_Z, S_LIFE, S_WR, S_DONE
  } state_t;

  state_t             state;
  logic [15:0]        time_step;
  logic [CNT_W-1:0]   live_total;
  logic [CNT_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   wr_idx;
  logic               dropped;
  logic signed [31:0] vz_new;
  logic signed [31:0] z_new;

  particle_t          mem [MAX_PARTICLES];
  particle_t          rd_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  particle_t          mem_wd;
  logic               mem_re;

  alu_ctrl_t          alu_ctrl;
  logic signed [31:0] alu_a;
  logic signed [32:0] alu_b;
  logic signed [31:0] alu_res;
  logic [25:0]        dv;

  logic in_acc;
  logic spawn_ok;
  logic keep;

  assign in_ready = (state == S_IDLE) && !rst;
  assign in_acc   = in_valid && in_ready;
  assign spawn_ok = in_acc && (in_data.action == ACT_SPAWN) &&
                    (live_total < CNT_W'(MAX_PARTICLES));
  assign dv       = time_step * GRAVITY;
  assign keep     = (state == S_WR) && (alu_res > 32'sd0);

  // ALU operand select, one operation per arithmetic state (S_VZ, S_MUL, S_Z, S_LIFE)
  always_comb begin
    alu_ctrl.en = 1'b1;
    alu_ctrl.op = ALU_ADD;
    alu_a       = rd_q.vz;
    alu_b       = -$signed({7'b0, dv});
    case (state)
      S_VZ: begin
        alu_a = rd_q.vz;
        alu_b = -$signed({7'b0, dv});
      end
      S_MUL: begin
        alu_ctrl.op = ALU_MUL;
        alu_a       = alu_res;
        alu_b       = '0;
      end
      S_Z: begin
        alu_a = rd_q.z;
        alu_b = {alu_res[31], alu_res};
      end
      S_LIFE: begin
        alu_a = rd_q.life;
        alu_b = -$signed({17'b0, time_step});
      end
      default: alu_ctrl.en = 1'b0;
    endcase
  end

  ppes_alu u_alu (
    .clk  (clk),
    .ctrl (alu_ctrl),
    .a    (alu_a),
    .b    (alu_b),
    .dt   (time_step),
    .res  (alu_res)
  );

  // memory port: spawn append or compacting write-back
  always_comb begin
    mem_re = (state == S_RD);
    if (spawn_ok) begin
      mem_we = 1'b1;
      mem_wa = live_total[ADDR_W-1:0];
      mem_wd = '{x: in_data.spawn_x, y: in_data.spawn_y, z: in_data.spawn_z,
                 vz: SPAWN_SPEED, life: LIFE_ONE};
    end else begin
      mem_we = keep;
      mem_wa = wr_idx[ADDR_W-1:0];
      mem_wd = '{x: rd_q.x, y: rd_q.y, z: z_new, vz: vz_new, life: alu_res};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      time_step  <= TIME_STEP_RESET;
      live_total <= '0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        time_step <= cfg_data;
      end
      // output register: load a finished result, or retire the taken one
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid              <= 1'b1;
        out_data.alive_count   <= live_total;
        out_data.spawn_dropped <= dropped;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            rd_idx  <= '0;
            wr_idx  <= '0;
            dropped <= 1'b0;
            if (in_data.action == ACT_SPAWN) begin
              if (spawn_ok) begin
                live_total <= live_total + 1'b1;
              end else begin
                dropped <= 1'b1;
              end
              state <= S_DONE;
            end else if (live_total == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD:   state <= S_VZ;
        S_VZ:   state <= S_MUL;
        S_MUL: begin
          vz_new <= alu_res;
          state  <= S_Z;
        end
        S_Z:    state <= S_LIFE;
        S_LIFE: begin
          z_new <= alu_res;
          state <= S_WR;
        end
        S_WR: begin
          if (keep) begin
            wr_idx <= wr_idx + 1'b1;
          end
          rd_idx <= rd_idx + 1'b1;
          if (rd_idx + 1'b1 == live_total) begin
            live_total <= keep ? wr_idx + 1'b1 : wr_idx;
            state      <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // compaction never overtakes the reader
  `PPES_ASSERT_NOW(a_wr_behind_rd, state != S_IDLE, wr_idx <= rd_idx)
  `PPES_ASSERT_NOW(a_count_bound, 1'b1, live_total <= CNT_W'(MAX_PARTICLES))
  // an accepted spawn with room grows the pool by exactly one
  `PPES_ASSERT_NEXT(a_spawn_grows, spawn_ok,
                    live_total == $past(live_total) + 1'b1)
  `PPES_ASSERT_NEXT(a_result_from_done, !out_valid && state == S_IDLE,
                    !out_valid || $past(state) == S_DONE)

endmodule
